>>> rtl/cdq_pkg.sv
`default_nettype none
package cdq_pkg;

  localparam int DATA_W        = 32;
  localparam int FILL_W        = 4;
  localparam int DEPTH_DEFAULT = 8;

  typedef logic [1:0]               kind_t;
  typedef logic [1:0]               status_t;
  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [FILL_W-1:0]        fill_t;

  localparam kind_t KIND_PUSH_REAR  = 2'd0;
  localparam kind_t KIND_POP_FRONT  = 2'd1;
  localparam kind_t KIND_PUSH_FRONT = 2'd2;
  localparam kind_t KIND_POP_REAR   = 2'd3;

  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_OVERFLOW  = 2'd1;
  localparam status_t ST_UNDERFLOW = 2'd2;

endpackage
`default_nettype wire

>>> rtl/cdq_if.sv
`default_nettype none
interface cdq_in_if
  import cdq_pkg::*;
  ();
  logic  valid;
  logic  ready;
  kind_t kind;
  word_t push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface cdq_out_if
  import cdq_pkg::*;
  ();
  logic    valid;
  logic    ready;
  word_t   pop_value;
  status_t status;
  fill_t   fill_level;

  modport source (output valid, output pop_value, output status, output fill_level,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input fill_level,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/circular_deque.sv
// The result of an item is presented in the cycle after the item is accepted.
// Throughput: one item per cycle while results are taken as they appear; the output
// register frees up in the cycle its result is taken, so a new item enters then.
// The storage memory sees at most one write or one registered read per item.
// Reset clears the head and tail pointers, the fill count and the output valid flag;
// the storage memory is not cleared.
`default_nettype none
module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cdq_in_if.sink     in_ch,
  cdq_out_if.source  out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic          out_valid_r;
  logic          out_pop_r, out_pop_nxt;
  status_t       out_status_r, out_status_nxt;
  fill_t         out_fill_r;

  word_t         mem [DEPTH];
  word_t         rdata_r;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;

  logic          accept, full, empty;
  logic [CW+FILL_W-1:0] fill_ext;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CW'(DEPTH));
  assign empty       = (count_r == '0);

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    we             = 1'b0;
    re             = 1'b0;
    waddr          = tail_r;
    raddr          = head_r;
    out_pop_nxt    = 1'b0;
    out_status_nxt = ST_DONE;
    if (accept) begin
      case (in_ch.kind)
        KIND_PUSH_REAR: begin
          if (full) begin
            out_status_nxt = ST_OVERFLOW;
          end else begin
            we        = 1'b1;
            waddr     = tail_r;
            tail_nxt  = wrap_inc(tail_r);
            count_nxt = count_r + CW'(1);
          end
        end
        KIND_PUSH_FRONT: begin
          if (full) begin
            out_status_nxt = ST_OVERFLOW;
          end else begin
            we        = 1'b1;
            head_nxt  = wrap_dec(head_r);
            waddr     = head_nxt;
            count_nxt = count_r + CW'(1);
          end
        end
        KIND_POP_FRONT: begin
          if (empty) begin
            out_status_nxt = ST_UNDERFLOW;
          end else begin
            re          = 1'b1;
            out_pop_nxt = 1'b1;
            raddr       = head_r;
            head_nxt    = wrap_inc(head_r);
            count_nxt   = count_r - CW'(1);
          end
        end
        default: begin
          if (empty) begin
            out_status_nxt = ST_UNDERFLOW;
          end else begin
            re          = 1'b1;
            out_pop_nxt = 1'b1;
            tail_nxt    = wrap_dec(tail_r);
            raddr       = tail_nxt;
            count_nxt   = count_r - CW'(1);
          end
        end
      endcase
    end
  end

  // The fill level field is narrower or wider than the count depending on DEPTH.
  assign fill_ext = {{FILL_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= in_ch.push_value;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_pop_r    <= out_pop_nxt;
      out_status_r <= out_status_nxt;
      out_fill_r   <= fill_ext[FILL_W-1:0];
    end
  end

  // The read data register only changes on an accepted pop, so it holds while stalled.
  assign out_ch.valid      = out_valid_r;
  assign out_ch.pop_value  = out_pop_r ? rdata_r : '0;
  assign out_ch.status     = out_status_r;
  assign out_ch.fill_level = out_fill_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count exceeds depth");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_OVERFLOW) |-> full)
    else $error("overflow reported while not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_UNDERFLOW) |-> empty)
    else $error("underflow reported while not empty");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !full && (in_ch.kind == KIND_PUSH_REAR || in_ch.kind == KIND_PUSH_FRONT))
    |=> (count_r == $past(count_r) + CW'(1)))
    else $error("successful push did not raise the fill count");
`endif

endmodule
`default_nettype wire
